// File: design/rbs_pkg.sv
// Shared types and constants for the ray versus box slab test.
// Used by every module of the block; depends on nothing.
package rbs_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CRD_W     = 32;
  localparam int unsigned DIST_W    = 31;
  localparam int unsigned EPS_W     = 16;
  localparam int unsigned T_W       = CRD_W + 2;
  // One register for operand setup, then one quotient bit per stage.
  localparam int unsigned DIV_LAT   = CRD_W + 1;

  localparam logic CFG_EPS  = 1'b0;
  localparam logic CFG_MAXD = 1'b1;

  typedef struct packed {
    logic [CRD_W-1:0] mag_lo;
    logic [CRD_W-1:0] mag_hi;
    logic [CRD_W-1:0] den;
    logic             neg_lo;
    logic             neg_hi;
  } div_op_t;

  typedef struct packed {
    logic [2:0][CRD_W-1:0] origin;
    logic [2:0][CRD_W-1:0] dir;
    logic [2:0]            par;
    logic [2:0]            par_miss;
  } side_t;

  typedef struct packed {
    logic                  hit;
    logic [DIST_W-1:0]     tnear;
    logic [2:0][CRD_W-1:0] origin;
    logic [2:0][CRD_W-1:0] dir;
  } span_t;

endpackage

// File: design/rbs_front.sv
// Input stage: slab numerator magnitudes, divisor, quotient signs and parallel tests.
// Depends on rbs_pkg.
module rbs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [2:0][rbs_pkg::CRD_W-1:0]  origin_i,
  input  logic [2:0][rbs_pkg::CRD_W-1:0]  dir_i,
  input  logic [2:0][rbs_pkg::CRD_W-1:0]  lo_i,
  input  logic [2:0][rbs_pkg::CRD_W-1:0]  hi_i,
  input  logic [rbs_pkg::EPS_W-1:0]       eps_i,
  output logic                            valid_o,
  output rbs_pkg::div_op_t [2:0]          op_o,
  output rbs_pkg::side_t                  side_o
);

  rbs_pkg::div_op_t [2:0] op_d;
  rbs_pkg::side_t         side_d;
  logic                   valid_q;
  rbs_pkg::div_op_t [2:0] op_q;
  rbs_pkg::side_t         side_q;

  always_comb begin
    logic signed [rbs_pkg::CRD_W:0] dlo;
    logic signed [rbs_pkg::CRD_W:0] dhi;
    logic [rbs_pkg::CRD_W-1:0]      den;
    side_d.origin = origin_i;
    side_d.dir    = dir_i;
    for (int a = 0; a < 3; a++) begin
      dlo = $signed({lo_i[a][rbs_pkg::CRD_W-1], lo_i[a]})
          - $signed({origin_i[a][rbs_pkg::CRD_W-1], origin_i[a]});
      dhi = $signed({hi_i[a][rbs_pkg::CRD_W-1], hi_i[a]})
          - $signed({origin_i[a][rbs_pkg::CRD_W-1], origin_i[a]});
      den = dir_i[a][rbs_pkg::CRD_W-1] ? (~dir_i[a] + 1'b1) : dir_i[a];
      op_d[a].mag_lo = dlo[rbs_pkg::CRD_W] ? rbs_pkg::CRD_W'(-dlo) : dlo[rbs_pkg::CRD_W-1:0];
      op_d[a].mag_hi = dhi[rbs_pkg::CRD_W] ? rbs_pkg::CRD_W'(-dhi) : dhi[rbs_pkg::CRD_W-1:0];
      op_d[a].den    = den;
      op_d[a].neg_lo = dlo[rbs_pkg::CRD_W] ^ dir_i[a][rbs_pkg::CRD_W-1];
      op_d[a].neg_hi = dhi[rbs_pkg::CRD_W] ^ dir_i[a][rbs_pkg::CRD_W-1];
      side_d.par[a]  = den <= {{(rbs_pkg::CRD_W-rbs_pkg::EPS_W){1'b0}}, eps_i};
      side_d.par_miss[a] = side_d.par[a] &&
                           (($signed(origin_i[a]) < $signed(lo_i[a])) ||
                            ($signed(origin_i[a]) > $signed(hi_i[a])));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign side_o  = side_q;

endmodule

// File: design/rbs_slab_div.sv
// Pipelined restoring divider for one slab distance, one quotient bit per stage.
// Quotients of 2^32 or more saturate there, which keeps every comparison intact.
// Depends on rbs_pkg.
module rbs_slab_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [rbs_pkg::CRD_W-1:0]         mag_i,
  input  logic [rbs_pkg::CRD_W-1:0]         den_i,
  input  logic                              neg_i,
  output logic signed [rbs_pkg::T_W-1:0]    t_o
);

  localparam int unsigned W = rbs_pkg::CRD_W;
  localparam int unsigned F = rbs_pkg::FRAC_BITS;

  logic [W-1:0] rem_q [0:W];
  logic [W-1:0] low_q [0:W];
  logic [W-1:0] quo_q [0:W];
  logic [W-1:0] den_q [0:W];
  logic         ovf_q [0:W];
  logic         neg_q [0:W];

  logic [W-1:0] top_part;
  logic [rbs_pkg::T_W-1:0] mag;

  assign top_part = {{(W-F){1'b0}}, mag_i[W-1:W-F]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= top_part;
      low_q[0] <= {mag_i[W-F-1:0], {F{1'b0}}};
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= top_part >= den_i;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;
    assign trial = {rem_q[k-1], low_q[k-1][W-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? W'(trial - {1'b0, den_q[k-1]}) : trial[W-1:0];
        low_q[k] <= {low_q[k-1][W-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][W-2:0], ge};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign mag = ovf_q[W] ? {2'b01, {W{1'b0}}} : {2'b00, quo_q[W]};
  assign t_o = neg_q[W] ? -$signed(mag) : $signed(mag);

endmodule

// File: design/rbs_interval.sv
// Orders each slab's distances and narrows the interval [0, max_distance].
// Depends on rbs_pkg.
module rbs_interval (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  rbs_pkg::side_t                        side_i,
  input  logic signed [2:0][rbs_pkg::T_W-1:0]   t_lo_i,
  input  logic signed [2:0][rbs_pkg::T_W-1:0]   t_hi_i,
  input  logic [rbs_pkg::DIST_W-1:0]            max_dist_i,
  output logic                                  valid_o,
  output rbs_pkg::span_t                        span_o
);

  rbs_pkg::span_t span_d;
  rbs_pkg::span_t span_q;
  logic           valid_q;

  always_comb begin
    logic signed [rbs_pkg::T_W-1:0] near;
    logic signed [rbs_pkg::T_W-1:0] far;
    logic signed [rbs_pkg::T_W-1:0] ent;
    logic signed [rbs_pkg::T_W-1:0] ext;
    logic                           swap;
    near = '0;
    far  = $signed({{(rbs_pkg::T_W-rbs_pkg::DIST_W){1'b0}}, max_dist_i});
    for (int a = 0; a < 3; a++) begin
      // Elements of a packed array select as unsigned, so compare them as signed.
      swap = $signed(t_lo_i[a]) > $signed(t_hi_i[a]);
      ent = swap ? $signed(t_hi_i[a]) : $signed(t_lo_i[a]);
      ext = swap ? $signed(t_lo_i[a]) : $signed(t_hi_i[a]);
      if (!side_i.par[a]) begin
        if (ent > near) near = ent;
        if (ext < far)  far  = ext;
      end
    end
    // The interval only narrows, so one final emptiness check suffices.
    span_d.hit    = !(|side_i.par_miss) && !(near > far);
    span_d.tnear  = near[rbs_pkg::DIST_W-1:0];
    span_d.origin = side_i.origin;
    span_d.dir    = side_i.dir;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      span_q <= span_d;
    end
  end

  assign valid_o = valid_q;
  assign span_o  = span_q;

endmodule

// File: design/rbs_point.sv
// Hit point: direction times entry distance, floored, added to the origin, saturated.
// Two stages; the second is the output register. Depends on rbs_pkg.
module rbs_point (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  rbs_pkg::span_t                       span_i,
  output logic                                 valid_o,
  output logic                                 hit_o,
  output logic [rbs_pkg::DIST_W-1:0]           dist_o,
  output logic [2:0][rbs_pkg::CRD_W-1:0]       point_o
);

  localparam int unsigned W = rbs_pkg::CRD_W;
  localparam int unsigned PW = 2 * W;

  logic                          v1_q;
  logic                          hit1_q;
  logic [rbs_pkg::DIST_W-1:0]    dist1_q;
  logic [2:0][W-1:0]             org1_q;
  logic signed [2:0][PW-1:0]     prod1_q;
  logic                          v2_q;
  logic                          hit2_q;
  logic [rbs_pkg::DIST_W-1:0]    dist2_q;
  logic [2:0][W-1:0]             pt2_q;
  logic [2:0][W-1:0]             pt_d;

  always_comb begin
    logic signed [PW-1:0] sum;
    for (int a = 0; a < 3; a++) begin
      sum = $signed({{W{org1_q[a][W-1]}}, org1_q[a]})
          + ($signed(prod1_q[a]) >>> rbs_pkg::FRAC_BITS);
      if (sum > $signed({{(W+1){1'b0}}, {(W-1){1'b1}}})) begin
        pt_d[a] = {1'b0, {(W-1){1'b1}}};
      end else if (sum < $signed({{(W+1){1'b1}}, {(W-1){1'b0}}})) begin
        pt_d[a] = {1'b1, {(W-1){1'b0}}};
      end else begin
        pt_d[a] = sum[W-1:0];
      end
      if (!hit1_q) pt_d[a] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit1_q  <= span_i.hit;
      dist1_q <= span_i.hit ? span_i.tnear : '0;
      org1_q  <= span_i.origin;
      for (int a = 0; a < 3; a++) begin
        prod1_q[a] <= $signed(span_i.dir[a]) * $signed({1'b0, span_i.tnear});
      end
      hit2_q  <= hit1_q;
      dist2_q <= dist1_q;
      pt2_q   <= pt_d;
    end
  end

  assign valid_o = v2_q;
  assign hit_o   = hit2_q;
  assign dist_o  = dist2_q;
  assign point_o = pt2_q;

endmodule

// File: design/ray_box_slab_intersection.sv
// Ray versus axis-aligned box slab test, top level.
// Depends on rbs_pkg, rbs_front, rbs_slab_div, rbs_interval and rbs_point.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one ray and one box per
//   transfer, all signed Q16.16. Output channel (out_valid_o / out_ready_i)
//   carries one result per input: hit flag, entry distance and hit point.
//   The configuration port writes parallel_epsilon (index 0) and
//   max_distance (index 1); write it only while no item is in flight.
//   A transfer passes the front stage, the six slab dividers (one quotient
//   bit per stage, most of the depth), the interval stage and point stages.
//   Throughput is one item per cycle while the receiver does not stall.
//   Reset empties the pipeline and restores the register defaults
//   (epsilon 0, max_distance 0x7FFFFFFF).
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready_o drops; nothing is lost or repeated, and bubbles in the
//   pipeline do not block acceptance while the output register is free.
module ray_box_slab_intersection (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [rbs_pkg::DIST_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [rbs_pkg::CRD_W-1:0] origin_x_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] origin_y_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] origin_z_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] dir_x_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] dir_y_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] dir_z_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] box_min_x_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] box_min_y_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] box_min_z_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] box_max_x_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] box_max_y_i,
  input  logic signed [rbs_pkg::CRD_W-1:0] box_max_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [rbs_pkg::DIST_W-1:0]       distance_o,
  output logic signed [rbs_pkg::CRD_W-1:0] point_x_o,
  output logic signed [rbs_pkg::CRD_W-1:0] point_y_o,
  output logic signed [rbs_pkg::CRD_W-1:0] point_z_o
);

  logic [rbs_pkg::EPS_W-1:0]  eps_q;
  logic [rbs_pkg::DIST_W-1:0] maxd_q;
  logic                       en;

  logic                                front_vld;
  rbs_pkg::div_op_t [2:0]              front_op;
  rbs_pkg::side_t                      front_side;
  logic signed [2:0][rbs_pkg::T_W-1:0] t_lo;
  logic signed [2:0][rbs_pkg::T_W-1:0] t_hi;

  logic           dly_vld_q  [0:rbs_pkg::DIV_LAT-1];
  rbs_pkg::side_t dly_side_q [0:rbs_pkg::DIV_LAT-1];

  logic                                iv_vld;
  rbs_pkg::span_t                      iv_span;
  logic [2:0][rbs_pkg::CRD_W-1:0]      point;

  // The pipeline moves whenever the output register is empty or drained.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q  <= '0;
      maxd_q <= {rbs_pkg::DIST_W{1'b1}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbs_pkg::CFG_EPS:  eps_q  <= cfg_wdata_i[rbs_pkg::EPS_W-1:0];
        rbs_pkg::CFG_MAXD: maxd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rbs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .origin_i ({origin_z_i, origin_y_i, origin_x_i}),
    .dir_i    ({dir_z_i, dir_y_i, dir_x_i}),
    .lo_i     ({box_min_z_i, box_min_y_i, box_min_x_i}),
    .hi_i     ({box_max_z_i, box_max_y_i, box_max_x_i}),
    .eps_i    (eps_q),
    .valid_o  (front_vld),
    .op_o     (front_op),
    .side_o   (front_side)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_slab_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (front_op[a].mag_lo),
      .den_i (front_op[a].den),
      .neg_i (front_op[a].neg_lo),
      .t_o   (t_lo[a])
    );
    rbs_slab_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (front_op[a].mag_hi),
      .den_i (front_op[a].den),
      .neg_i (front_op[a].neg_hi),
      .t_o   (t_hi[a])
    );
  end

  // Side data walks alongside the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rbs_pkg::DIV_LAT; k++) dly_vld_q[k] <= 1'b0;
    end else if (en) begin
      dly_vld_q[0] <= front_vld;
      for (int k = 1; k < rbs_pkg::DIV_LAT; k++) dly_vld_q[k] <= dly_vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_side_q[0] <= front_side;
      for (int k = 1; k < rbs_pkg::DIV_LAT; k++) dly_side_q[k] <= dly_side_q[k-1];
    end
  end

  rbs_interval u_interval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dly_vld_q[rbs_pkg::DIV_LAT-1]),
    .side_i     (dly_side_q[rbs_pkg::DIV_LAT-1]),
    .t_lo_i     (t_lo),
    .t_hi_i     (t_hi),
    .max_dist_i (maxd_q),
    .valid_o    (iv_vld),
    .span_o     (iv_span)
  );

  rbs_point u_point (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (iv_vld),
    .span_i  (iv_span),
    .valid_o (out_valid_o),
    .hit_o   (hit_o),
    .dist_o  (distance_o),
    .point_o (point)
  );

  assign point_x_o = point[0];
  assign point_y_o = point[1];
  assign point_z_o = point[2];

endmodule

// File: design/rbs_checker.sv
// Port-level checks for the ray versus box slab test, bound to the top level.
// Depends on rbs_pkg and ray_box_slab_intersection.
module rbs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             hit_o,
  input logic [rbs_pkg::DIST_W-1:0]       distance_o,
  input logic signed [rbs_pkg::CRD_W-1:0] point_x_o,
  input logic signed [rbs_pkg::CRD_W-1:0] point_y_o,
  input logic signed [rbs_pkg::CRD_W-1:0] point_z_o
);

  // A stalled result holds valid, hit, distance and point_x until transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(distance_o) && $stable(point_x_o))
    else $error("result changed while stalled");

  // A miss reports zero distance and a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> distance_o == '0 && point_x_o == '0 &&
      point_y_o == '0 && point_z_o == '0)
    else $error("miss with nonzero payload");

  // Input is taken exactly when the output side can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track output stall");

endmodule

bind ray_box_slab_intersection rbs_checker u_rbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_o       (hit_o),
  .distance_o  (distance_o),
  .point_x_o   (point_x_o),
  .point_y_o   (point_y_o),
  .point_z_o   (point_z_o)
);

// File: tb/sv/tb_ray_box_slab_intersection.sv
// Self-checking testbench for the ray versus box slab intersection block.
// Depends on rbs_pkg and ray_box_slab_intersection; predicts each result in place.
`timescale 1ns / 1ps

module tb_ray_box_slab_intersection;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz;
  } ray_box_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        tdist;
    logic signed [31:0] px, py, pz;
  } hit_info_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = rbs_pkg::CFG_EPS;
  logic [rbs_pkg::DIST_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ray_box_t ray_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic [rbs_pkg::DIST_W-1:0] distance_o;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;

  hit_info_t expected_hits[$];
  logic [15:0] eps_cfg = 16'd0;
  logic [30:0] maxd_cfg = 31'h7FFFFFFF;
  int n_errors = 0;
  int n_results = 0;
  int n_hits = 0;
  bit stall_en = 1'b1;

  ray_box_slab_intersection dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .origin_x_i(ray_q.ox), .origin_y_i(ray_q.oy), .origin_z_i(ray_q.oz),
    .dir_x_i(ray_q.dx), .dir_y_i(ray_q.dy), .dir_z_i(ray_q.dz),
    .box_min_x_i(ray_q.lx), .box_min_y_i(ray_q.ly), .box_min_z_i(ray_q.lz),
    .box_max_x_i(ray_q.hx), .box_max_y_i(ray_q.hy), .box_max_z_i(ray_q.hz),
    .out_valid_o, .out_ready_i, .hit_o, .distance_o,
    .point_x_o, .point_y_o, .point_z_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint floor_shift(longint p);
    longint one;
    one = longint'(1) << rbs_pkg::FRAC_BITS;
    if (p >= 0) return p / one;
    return -((-p + one - 1) / one);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic hit_info_t slab_test(ray_box_t r);
    longint o[3], d[3], lo[3], hi[3];
    longint tn, tf, t1, t2, s, ad;
    hit_info_t res;
    bit hit;
    o = '{r.ox, r.oy, r.oz};
    d = '{r.dx, r.dy, r.dz};
    lo = '{r.lx, r.ly, r.lz};
    hi = '{r.hx, r.hy, r.hz};
    tn = 0;
    tf = longint'(maxd_cfg);
    hit = 1'b1;
    res = '0;
    for (int a = 0; a < 3 && hit; a++) begin
      ad = d[a] < 0 ? -d[a] : d[a];
      if (ad <= longint'(eps_cfg)) begin
        if (o[a] < lo[a] || o[a] > hi[a]) hit = 1'b0;
      end else begin
        // SystemVerilog division truncates toward zero, as required.
        t1 = ((lo[a] - o[a]) * (longint'(1) << rbs_pkg::FRAC_BITS)) / d[a];
        t2 = ((hi[a] - o[a]) * (longint'(1) << rbs_pkg::FRAC_BITS)) / d[a];
        if (t1 > t2) begin
          s = t1; t1 = t2; t2 = s;
        end
        if (t1 > tn) tn = t1;
        if (t2 < tf) tf = t2;
        if (tn > tf) hit = 1'b0;
      end
    end
    if (!hit) return res;
    res.hit = 1'b1;
    res.tdist = tn[30:0];
    res.px = clamp32(o[0] + floor_shift(d[0] * tn));
    res.py = clamp32(o[1] + floor_shift(d[1] * tn));
    res.pz = clamp32(o[2] + floor_shift(d[2] * tn));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin
    hit_info_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_hits.pop_front();
          n_results++;
          if (want.hit) n_hits++;
          if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
          if (distance_o !== want.tdist) report_mismatch("distance", distance_o, want.tdist);
          if (point_x_o !== want.px) report_mismatch("point_x", point_x_o, want.px);
          if (point_y_o !== want.py) report_mismatch("point_y", point_y_o, want.py);
          if (point_z_o !== want.pz) report_mismatch("point_z", point_z_o, want.pz);
        end
      end
      out_ready_i <= stall_en ? ($urandom_range(99) >= 32) : 1'b1;
    end
  end

  // Valid stays high between back-to-back transfers and drops only while idling.
  task automatic send_ray(ray_box_t r);
    if (stall_en) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    ray_q <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_hits.push_back(slab_test(r));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rbs_pkg::CFG_EPS) eps_cfg = value[15:0];
    else maxd_cfg = value;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 40))) - 20;
      default: return 32'($signed($urandom_range(0, 32'h00400000))) - 32'sh00200000;
    endcase
  endfunction

  // 70 percent aim from outside toward a random box, so most intervals survive.
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    logic signed [31:0] c, w;
    r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
    r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
    r.lx = rand_coord(); r.ly = rand_coord(); r.lz = rand_coord();
    r.hx = rand_coord(); r.hy = rand_coord(); r.hz = rand_coord();
    if ($urandom_range(99) < 70) begin
      c = 32'($signed($urandom_range(0, 32'h00100000))) - 32'sh00080000;
      w = $urandom_range(1, 32'h00040000);
      r.lx = c - w; r.hx = c + w;
      r.ly = c - w; r.hy = c + w;
      r.lz = c - w; r.hz = c + w;
      r.ox = c - 32'sh00200000 + 32'($signed($urandom_range(0, 32'h1000)));
      r.oy = c + 32'($signed($urandom_range(0, 32'h1000))) - 32'sh800;
      r.oz = c + 32'($signed($urandom_range(0, 32'h1000))) - 32'sh800;
      r.dx = $urandom_range(1, 32'h00020000);
      r.dy = 32'($signed($urandom_range(0, 32'h400))) - 32'sh200;
      r.dz = 32'($signed($urandom_range(0, 32'h400))) - 32'sh200;
    end
    return r;
  endfunction

  task automatic test_extremes;
    ray_box_t r;
    // Axis-aligned hit, parallel inside and outside, inverted box, extremes.
    r = '{0, 0, 0, 32'h10000, 0, 0, 32'h20000, -32'sh10000, -32'sh10000,
          32'h30000, 32'h10000, 32'h10000};
    send_ray(r);
    r.oy = 32'h20000; send_ray(r);
    r.oy = 0; r.lx = 32'h30000; r.hx = 32'h20000; send_ray(r);
    r = '{0, 0, 0, 32'h10000, 0, 0, 32'h20000, 32'h10000, -32'sh10000,
          32'h30000, -32'sh10000, 32'h10000};
    send_ray(r);
    r = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h7FFFFFFF};
    send_ray(r);
    r = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h7FFFFFFF};
    send_ray(r);
    r = '{0, 0, 0, -1, 1, -1, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    send_ray(r);
    r = '{32'h7FFFFFFF, 0, 0, 1, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0, 0};
    send_ray(r);
    // Ray pointing away from the box.
    r = '{0, 0, 0, -32'sh10000, 0, 0, 32'h20000, -1, -1, 32'h30000, 1, 1};
    send_ray(r);
    repeat (10) send_ray(rand_ray());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      stall_en = !(i >= n / 3 && i < n / 3 + 150);
      send_ray(rand_ray());
    end
    stall_en = 1'b1;
  endtask

  task automatic test_settings;
    write_reg(rbs_pkg::CFG_EPS, 31'd0);
    write_reg(rbs_pkg::CFG_MAXD, 31'h7FFFFFFF);
    test_random(500);
    write_reg(rbs_pkg::CFG_EPS, 31'd65535);
    test_random(300);
    write_reg(rbs_pkg::CFG_EPS, 31'd512);
    write_reg(rbs_pkg::CFG_MAXD, 31'd0);
    test_random(250);
    write_reg(rbs_pkg::CFG_MAXD, 31'h00180000);
    write_reg(rbs_pkg::CFG_EPS, 31'($urandom_range(65535)));
    test_random(300);
    write_reg(rbs_pkg::CFG_MAXD, 31'($urandom()));
    write_reg(rbs_pkg::CFG_EPS, 31'h5555);
    test_random(250);
    write_reg(rbs_pkg::CFG_EPS, 31'h2AAA);
    write_reg(rbs_pkg::CFG_MAXD, 31'h2AAAAAAA);
    test_random(280);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_settings();
    drain();
    $display("Checked %0d results (%0d hits) over several epsilon and range settings.",
             n_results, n_hits);
    if (n_errors == 0 && expected_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: ray_box_slab_intersection.f
design/rbs_pkg.sv
design/rbs_front.sv
design/rbs_slab_div.sv
design/rbs_interval.sv
design/rbs_point.sv
design/ray_box_slab_intersection.sv
design/rbs_checker.sv
tb/sv/tb_ray_box_slab_intersection.sv
